@@ rtl/msrs_pkg.sv @@
// Shared types and constants for the meter smoother with running statistics.
// No dependencies; imported by every module of the block.
package msrs_pkg;

    localparam int STAT_CHANNELS    = 10;
    localparam int COUNT_BITS       = 16;
    localparam int SMOOTHED_METRICS = 5;
    localparam int LVL_SLOTS        = 8;

    localparam logic [2:0] LVL_PRE   = 3'd5;
    localparam logic [2:0] LVL_POST  = 3'd6;
    localparam logic [2:0] LVL_SCORE = 3'd7;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    localparam int STAT_IDX_W = (STAT_CHANNELS > 1) ? $clog2(STAT_CHANNELS) : 1;
    localparam int DEN_W      = COUNT_BITS + 1;
    localparam int NUM_W      = ((COUNT_BITS > 18) ? COUNT_BITS : 18) + 1;
    localparam int DIV_CNT_W  = $clog2(NUM_W + 1);

    localparam int PADDR_W = 3;
    localparam logic [0:0] REG_RISE = 1'b0;
    localparam logic [0:0] REG_FALL = 1'b1;
    localparam logic [15:0] RISE_RESET = 16'd18350;
    localparam logic [15:0] FALL_RESET = 16'd7864;

    typedef struct packed {
        logic capture;
        logic mul;
        logic upd;
        logic second;
        logic div_start;
        logic stat_wr;
        logic out_load;
    } msrs_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic is_post;
    } msrs_status_t;

endpackage

@@ rtl/msrs_regs.sv @@
// APB-style configuration registers: rise and fall smoothing coefficients.
// Depends on msrs_pkg.
module msrs_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msrs_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [15:0]                   rise_alpha,
    output logic [15:0]                   fall_alpha
);
    import msrs_pkg::*;

    logic [15:0] rise_reg, rise_next;
    logic [15:0] fall_reg, fall_next;
    logic        wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        rise_next = rise_reg;
        fall_next = fall_reg;
        if (wr_en) begin
            case (paddr[2:2])
                REG_RISE: rise_next = pwdata[15:0];
                REG_FALL: fall_next = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2:2])
            REG_RISE: prdata = {16'd0, rise_reg};
            REG_FALL: prdata = {16'd0, fall_reg};
            default:  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rise_reg <= RISE_RESET;
            fall_reg <= FALL_RESET;
        end else begin
            rise_reg <= rise_next;
            fall_reg <= fall_next;
        end
    end

    assign rise_alpha = rise_reg;
    assign fall_alpha = fall_reg;

endmodule

@@ rtl/msrs_div.sv @@
// Restoring divider, one quotient bit per cycle, for the running-mean step.
// Depends on msrs_pkg.
module msrs_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [msrs_pkg::NUM_W-1:0]  num,
    input  logic [msrs_pkg::DEN_W-1:0]  den,
    output logic                        busy,
    output logic [msrs_pkg::NUM_W-1:0]  quo
);
    import msrs_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [DEN_W:0]       rem_sh;
    logic                 fits;

    assign rem_sh = {rem_reg, quo_reg[NUM_W-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_comb begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        if (start) begin
            cnt_next = DIV_CNT_W'(NUM_W);
            rem_next = '0;
            quo_next = num;
            den_next = den;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            rem_next = fits ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy = cnt_reg != '0;
    assign quo  = quo_reg;

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy)
        else $error("divider not busy after start");

endmodule

@@ rtl/msrs_dp.sv @@
// Datapath: channel state, shared smoother multiplier, stats update, result register.
// Depends on msrs_pkg and msrs_div.
module msrs_dp (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  msrs_pkg::msrs_cmd_t     cmd,
    output msrs_pkg::msrs_status_t  status,
    input  logic [3:0]              s_channel,
    input  logic signed [23:0]      s_sample,
    input  logic signed [23:0]      s_overall_score,
    input  logic [15:0]             rise_alpha,
    input  logic [15:0]             fall_alpha,
    output logic [3:0]              m_channel_echo,
    output logic signed [23:0]      m_smoothed_level,
    output logic signed [23:0]      m_score_level,
    output logic [16:0]             m_stat_min,
    output logic [16:0]             m_stat_max,
    output logic [16:0]             m_stat_mean,
    output logic [15:0]             m_sample_count
);
    import msrs_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [3:0]               ch_reg;
    logic signed [23:0]       smp_reg;
    logic signed [23:0]       ovr_reg;
    logic signed [23:0]       lvl_reg [LVL_SLOTS];
    logic [16:0]              min_reg [STAT_CHANNELS];
    logic [16:0]              max_reg [STAT_CHANNELS];
    logic [16:0]              mean_reg [STAT_CHANNELS];
    logic [COUNT_BITS-1:0]    cnt_reg [STAT_CHANNELS];
    logic signed [41:0]       prod_reg, prod_next;

    logic [3:0]               ch_out_reg;
    logic signed [23:0]       lvl_out_reg;
    logic signed [23:0]       score_out_reg;
    logic [16:0]              min_out_reg;
    logic [16:0]              max_out_reg;
    logic [16:0]              mean_out_reg;
    logic [15:0]              cnt_out_reg;

    logic [4:0]               ch_ext;
    logic                     metric, is_pre, is_post, smooth_en;
    logic signed [23:0]       target, level;
    logic [2:0]               slot;
    logic signed [24:0]       diff;
    logic [15:0]              alpha;
    logic signed [41:0]       rnd;
    logic [25:0]              lvl_sum;
    logic signed [23:0]       lvl_next;

    logic [STAT_IDX_W-1:0]    idx;
    logic [16:0]              v, min_old, max_old, mean_old, ad, q, mean_upd;
    logic [16:0]              min_next, max_next, mean_next;
    logic [COUNT_BITS-1:0]    cnt_old, n_new;
    logic                     first, d_neg;
    logic [NUM_W-1:0]         div_num, div_quo;
    logic [DEN_W-1:0]         div_den;
    logic                     div_busy;
    logic [31:0]              cnt_ext;

    assign ch_ext    = {1'b0, ch_reg};
    assign metric    = ch_ext < 5'(STAT_CHANNELS);
    assign is_pre    = ch_ext == 5'(STAT_CHANNELS);
    assign is_post   = ch_ext == 5'(STAT_CHANNELS + 1);
    assign smooth_en = (metric && ch_ext < 5'(SMOOTHED_METRICS)) || is_pre || is_post;
    assign target    = ((is_pre || is_post) && !(smp_reg > 24'sd0)) ? ovr_reg : smp_reg;

    always_comb begin
        if (cmd.second) begin
            slot = LVL_SCORE;
        end else if (is_pre) begin
            slot = LVL_PRE;
        end else if (is_post) begin
            slot = LVL_POST;
        end else begin
            slot = ch_reg[2:0];
        end
    end

    assign level     = lvl_reg[slot];
    assign diff      = 25'(target) - 25'(level);
    assign alpha     = (target > level) ? rise_alpha : fall_alpha;
    assign prod_next = diff * $signed({1'b0, alpha});
    assign rnd       = prod_reg + 42'sd32768;
    assign lvl_sum   = 26'(level) + rnd[41:16];
    assign lvl_next  = lvl_sum[23:0];

    // running statistics
    assign idx = metric ? ch_reg[STAT_IDX_W-1:0] : '0;

    always_comb begin
        if (smp_reg < 24'sd0) begin
            v = '0;
        end else if (smp_reg > 24'sd65536) begin
            v = ONE_Q16;
        end else begin
            v = smp_reg[16:0];
        end
    end

    assign cnt_old  = cnt_reg[idx];
    assign min_old  = min_reg[idx];
    assign max_old  = max_reg[idx];
    assign mean_old = mean_reg[idx];
    assign first    = cnt_old == '0;
    assign n_new    = first ? COUNT_BITS'(1)
                    : ((cnt_old == CNT_MAX) ? cnt_old : cnt_old + COUNT_BITS'(1));
    assign d_neg    = v < mean_old;
    assign ad       = d_neg ? mean_old - v : v - mean_old;
    assign div_num  = (NUM_W'(ad) << 1) + NUM_W'(n_new);
    assign div_den  = {n_new, 1'b0};
    assign q        = div_quo[16:0];
    assign mean_upd = d_neg ? mean_old - q : mean_old + q;

    assign min_next  = (first || v < min_old) ? v : min_old;
    assign max_next  = (first || v > max_old) ? v : max_old;
    assign mean_next = first ? v : mean_upd;
    assign cnt_ext   = 32'(cnt_old);

    msrs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            ch_reg  <= s_channel;
            smp_reg <= s_sample;
            ovr_reg <= s_overall_score;
        end
        if (cmd.mul) begin
            prod_reg <= prod_next;
        end
        if (cmd.out_load) begin
            ch_out_reg    <= ch_reg;
            lvl_out_reg   <= smooth_en ? level : 24'sd0;
            score_out_reg <= lvl_reg[LVL_SCORE];
            min_out_reg   <= metric ? min_old : '0;
            max_out_reg   <= metric ? max_old : '0;
            mean_out_reg  <= metric ? mean_old : '0;
            cnt_out_reg   <= metric ? cnt_ext[15:0] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LVL_SLOTS; i++) begin
                lvl_reg[i] <= '0;
            end
            for (int i = 0; i < STAT_CHANNELS; i++) begin
                min_reg[i]  <= '0;
                max_reg[i]  <= '0;
                mean_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end else begin
            if (cmd.upd && smooth_en) begin
                lvl_reg[slot] <= lvl_next;
            end
            if (cmd.stat_wr && metric) begin
                min_reg[idx]  <= min_next;
                max_reg[idx]  <= max_next;
                mean_reg[idx] <= mean_next;
                cnt_reg[idx]  <= n_new;
            end
        end
    end

    assign status.div_busy = div_busy;
    assign status.is_post  = is_post;

    assign m_channel_echo   = ch_out_reg;
    assign m_smoothed_level = lvl_out_reg;
    assign m_score_level    = score_out_reg;
    assign m_stat_min       = min_out_reg;
    assign m_stat_max       = max_out_reg;
    assign m_stat_mean      = mean_out_reg;
    assign m_sample_count   = cnt_out_reg;

endmodule

@@ rtl/msrs_ctrl.sv @@
// Sequencer: input/output handshake and step order of the datapath.
// Depends on msrs_pkg.
module msrs_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    output msrs_pkg::msrs_cmd_t     cmd,
    input  msrs_pkg::msrs_status_t  status
);
    import msrs_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_UPD  = 7'b0000100,
        ST_MUL2 = 7'b0001000,
        ST_UPD2 = 7'b0010000,
        ST_WB   = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul       = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = ST_UPD;
            end
            ST_UPD: begin
                cmd.upd    = 1'b1;
                state_next = status.is_post ? ST_MUL2 : ST_WB;
            end
            ST_MUL2: begin
                cmd.mul    = 1'b1;
                cmd.second = 1'b1;
                state_next = ST_UPD2;
            end
            ST_UPD2: begin
                cmd.upd    = 1'b1;
                cmd.second = 1'b1;
                state_next = ST_WB;
            end
            ST_WB: begin
                if (!status.div_busy) begin
                    cmd.stat_wr = 1'b1;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten before it was taken");

    a_wb_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.stat_wr |-> !status.div_busy)
        else $error("stats written while divider busy");

    a_accept_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_MUL && !s_ready))
        else $error("accepted word not started");

endmodule

@@ rtl/meter_smoother_with_running_stats_core.sv @@
// Top level of the meter smoother with running min/max/mean statistics.
// Depends on msrs_pkg, msrs_regs, msrs_ctrl, msrs_dp (and msrs_div below it).
//
//   channel   direction  handshake               payload
//   s_        in         s_valid / s_ready       channel, sample, overall_score
//   m_        out        m_valid / m_ready       channel_echo, levels, min/max/mean, count
//   apb       in         psel, penable, pready   rise_alpha @0x0, fall_alpha @0x4
//
// One word at a time: a word is accepted only once the last result is loaded, at a pace
// set by the 19-step restoring divider of the mean update. A word on the post-score
// channel adds a second pass of the shared smoother multiplier (hidden behind the divider).
// Synchronous active-low reset clears all channel state; a stalled result waits in
// the output register while the next word is accepted and processed.
module meter_smoother_with_running_stats_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [3:0]                    s_channel,
    input  logic signed [23:0]            s_sample,
    input  logic signed [23:0]            s_overall_score,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [3:0]                    m_channel_echo,
    output logic signed [23:0]            m_smoothed_level,
    output logic signed [23:0]            m_score_level,
    output logic [16:0]                   m_stat_min,
    output logic [16:0]                   m_stat_max,
    output logic [16:0]                   m_stat_mean,
    output logic [15:0]                   m_sample_count,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msrs_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import msrs_pkg::*;

    msrs_cmd_t    cmd;
    msrs_status_t status;
    logic [15:0]  rise_alpha;
    logic [15:0]  fall_alpha;

    msrs_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .rise_alpha (rise_alpha),
        .fall_alpha (fall_alpha)
    );

    msrs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    msrs_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_channel        (s_channel),
        .s_sample         (s_sample),
        .s_overall_score  (s_overall_score),
        .rise_alpha       (rise_alpha),
        .fall_alpha       (fall_alpha),
        .m_channel_echo   (m_channel_echo),
        .m_smoothed_level (m_smoothed_level),
        .m_score_level    (m_score_level),
        .m_stat_min       (m_stat_min),
        .m_stat_max       (m_stat_max),
        .m_stat_mean      (m_stat_mean),
        .m_sample_count   (m_sample_count)
    );

endmodule

@@ tb/tb_meter_smoother_with_running_stats_core.sv @@
// Self-checking bench for meter_smoother_with_running_stats_core: drives words and alpha
// writes, predicts each result in-bench and compares it field by field. Needs msrs_pkg.
module tb_meter_smoother_with_running_stats_core;
    timeunit 1ns;
    timeprecision 1ps;

    import msrs_pkg::*;

    localparam int     STALL_LIMIT   = 4000;
    localparam int     SINK_HOLD     = 200;
    localparam int     SETTLE_CYCLES = 30;
    localparam longint UNIT          = 65536;
    localparam longint CNT_CAP       = (longint'(1) << COUNT_BITS) - 1;

    localparam logic signed [23:0] S_LO  = 24'sh800000;
    localparam logic signed [23:0] S_HI  = 24'sh7FFFFF;
    localparam logic signed [23:0] S_ONE = 24'sd65536;
    localparam logic [16:0]        U17   = 17'd65536;

    typedef struct packed {
        logic [3:0]         ch;
        logic signed [23:0] lvl;
        logic signed [23:0] score;
        logic [16:0]        mn;
        logic [16:0]        mx;
        logic [16:0]        mean;
        logic [15:0]        cnt;
    } meter_word_t;

    typedef struct packed {
        logic [3:0]         ch;
        logic signed [23:0] smp;
        logic signed [23:0] ovr;
        logic               typed;
        meter_word_t        want;
    } probe_row_t;

    // typed rows: values readable straight from reset state and the default alphas
    localparam probe_row_t PROBES [23] = '{
        '{4'd5,  S_ONE,   24'sd0, 1'b1, '{4'd5,  24'sd0, 24'sd0, U17, U17, U17, 16'd1}},
        '{4'd5,  S_LO,    24'sd0, 1'b1, '{4'd5,  24'sd0, 24'sd0, 17'd0, U17, 17'd32768, 16'd2}},
        '{4'd6,  S_HI,    S_LO,   1'b1, '{4'd6,  24'sd0, 24'sd0, U17, U17, U17, 16'd1}},
        '{4'd9,  24'sd0,  24'sd0, 1'b1, '{4'd9,  24'sd0, 24'sd0, 17'd0, 17'd0, 17'd0, 16'd1}},
        '{4'd12, S_ONE,   S_ONE,  1'b1, '{4'd12, 24'sd0, 24'sd0, 17'd0, 17'd0, 17'd0, 16'd0}},
        '{4'd15, S_HI,    S_LO,   1'b1, '{4'd15, 24'sd0, 24'sd0, 17'd0, 17'd0, 17'd0, 16'd0}},
        '{4'd0,  24'sd0,  24'sd0, 1'b1, '{4'd0,  24'sd0, 24'sd0, 17'd0, 17'd0, 17'd0, 16'd1}},
        '{4'd10, 24'sd0,  24'sd0, 1'b1, '{4'd10, 24'sd0, 24'sd0, 17'd0, 17'd0, 17'd0, 16'd0}},
        '{4'd11, -24'sd1, S_ONE,  1'b1,
            '{4'd11, 24'sd18350, 24'sd18350, 17'd0, 17'd0, 17'd0, 16'd0}},
        '{4'd0,  S_ONE,   24'sd0, 1'b0, '0},
        '{4'd0,  S_ONE,   24'sd0, 1'b0, '0},
        '{4'd1,  S_HI,    24'sd0, 1'b0, '0},
        '{4'd2,  S_LO,    24'sd0, 1'b0, '0},
        '{4'd3,  24'sd32768, 24'sd0, 1'b0, '0},
        '{4'd4,  24'sd65535, S_HI,   1'b0, '0},
        '{4'd7,  24'sd65537, 24'sd0, 1'b0, '0},
        '{4'd8,  -24'sd1, 24'sd0, 1'b0, '0},
        '{4'd11, S_ONE,   S_LO,   1'b0, '0},
        '{4'd11, 24'sd0,  S_LO,   1'b0, '0},
        '{4'd10, S_HI,    S_HI,   1'b0, '0},
        '{4'd10, S_LO,    S_LO,   1'b0, '0},
        '{4'd13, S_HI,    S_HI,   1'b0, '0},
        '{4'd11, S_HI,    24'sd0, 1'b0, '0}
    };

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [3:0]         s_channel;
    logic signed [23:0] s_sample;
    logic signed [23:0] s_overall_score;
    logic               m_valid;
    logic               m_ready;
    logic [3:0]         m_channel_echo;
    logic signed [23:0] m_smoothed_level;
    logic signed [23:0] m_score_level;
    logic [16:0]        m_stat_min;
    logic [16:0]        m_stat_max;
    logic [16:0]        m_stat_mean;
    logic [15:0]        m_sample_count;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // bench state
    logic        typed_ok;
    meter_word_t typed_word;
    logic        hold_req = 1'b0;
    logic        sink_idle = 1'b1;
    bit          src_idle = 1'b1;
    int          in_flight = 0;
    int          idle_run = 0;
    int          errors = 0;
    int          words_in = 0;
    int          words_out = 0;
    int          alpha_writes = 0;
    meter_word_t pending_q[$];

    // predictor state
    logic [15:0] rise_sh;
    logic [15:0] fall_sh;
    longint      lvl_mem[LVL_SLOTS];
    longint      min_mem[STAT_CHANNELS];
    longint      max_mem[STAT_CHANNELS];
    longint      mean_mem[STAT_CHANNELS];
    longint      cnt_mem[STAT_CHANNELS];

    meter_smoother_with_running_stats_core DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_channel        (s_channel),
        .s_sample         (s_sample),
        .s_overall_score  (s_overall_score),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_channel_echo   (m_channel_echo),
        .m_smoothed_level (m_smoothed_level),
        .m_score_level    (m_score_level),
        .m_stat_min       (m_stat_min),
        .m_stat_max       (m_stat_max),
        .m_stat_mean      (m_stat_mean),
        .m_sample_count   (m_sample_count),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #5 aclk = ~aclk;

    task automatic report(string what, longint got, longint want);
        errors++;
        if (errors <= 40) begin
            $display("MISMATCH %s: got %0d, want %0d (result %0d)", what, got, want, words_out);
        end
    endtask

    // one-pole step, round to nearest with ties up
    function automatic longint glide(longint level, longint target);
        longint a;
        a = (target > level) ? longint'(rise_sh) : longint'(fall_sh);
        return level + (((target - level) * a + 32768) >>> 16);
    endfunction

    function automatic meter_word_t advance_meter(logic [3:0] ch, logic signed [23:0] smp,
                                                  logic signed [23:0] ovr);
        meter_word_t r;
        longint sv, v, d, q, n, target;
        int c, slot;
        r = '0;
        c = ch;
        sv = smp;
        r.ch = ch;
        if (c < STAT_CHANNELS) begin
            v = (sv < 0) ? 0 : ((sv > UNIT) ? UNIT : sv);
            if (cnt_mem[c] == 0) begin
                min_mem[c] = v;
                max_mem[c] = v;
                mean_mem[c] = v;
                cnt_mem[c] = 1;
            end else begin
                if (v < min_mem[c]) min_mem[c] = v;
                if (v > max_mem[c]) max_mem[c] = v;
                if (cnt_mem[c] < CNT_CAP) cnt_mem[c] = cnt_mem[c] + 1;
                n = cnt_mem[c];
                d = v - mean_mem[c];
                q = (2 * ((d < 0) ? -d : d) + n) / (2 * n);
                mean_mem[c] = (d < 0) ? mean_mem[c] - q : mean_mem[c] + q;
            end
            if (c < SMOOTHED_METRICS) begin
                lvl_mem[c] = glide(lvl_mem[c], sv);
                r.lvl = 24'(lvl_mem[c]);
            end
            r.mn = 17'(min_mem[c]);
            r.mx = 17'(max_mem[c]);
            r.mean = 17'(mean_mem[c]);
            r.cnt = 16'(cnt_mem[c]);
        end else if (c == STAT_CHANNELS || c == STAT_CHANNELS + 1) begin
            target = (sv > 0) ? sv : longint'(ovr);
            slot = (c == STAT_CHANNELS) ? int'(LVL_PRE) : int'(LVL_POST);
            lvl_mem[slot] = glide(lvl_mem[slot], target);
            r.lvl = 24'(lvl_mem[slot]);
            if (slot == int'(LVL_POST)) begin
                lvl_mem[LVL_SCORE] = glide(lvl_mem[LVL_SCORE], target);
            end
        end
        r.score = 24'(lvl_mem[LVL_SCORE]);
        return r;
    endfunction

    function automatic logic signed [23:0] pick_value();
        logic signed [23:0] x;
        case ($urandom_range(0, 9))
            0, 1: x = 24'($urandom);
            2: begin
                case ($urandom_range(0, 7))
                    0: x = S_LO;
                    1: x = S_HI;
                    2: x = 24'sd0;
                    3: x = -24'sd1;
                    4: x = 24'sd1;
                    5: x = S_ONE;
                    6: x = 24'sd65535;
                    default: x = 24'sd65537;
                endcase
            end
            3: x = -24'($urandom_range(1, 65536));
            default: x = 24'($urandom_range(0, 65536));
        endcase
        return x;
    endfunction

    // word monitor: predicts on input accept, checks on output accept
    always @(posedge aclk) begin
        meter_word_t seen, want;
        logic in_acc, out_acc;
        in_acc = aresetn && s_valid && s_ready;
        out_acc = aresetn && m_valid && m_ready;
        if (in_acc) begin
            want = advance_meter(s_channel, s_sample, s_overall_score);
            if (typed_ok) want = typed_word;
            pending_q.push_back(want);
            words_in++;
        end
        if (out_acc) begin
            seen.ch = m_channel_echo;
            seen.lvl = m_smoothed_level;
            seen.score = m_score_level;
            seen.mn = m_stat_min;
            seen.mx = m_stat_max;
            seen.mean = m_stat_mean;
            seen.cnt = m_sample_count;
            words_out++;
            if (pending_q.size() == 0) begin
                report("result with nothing pending, channel", seen.ch, -1);
            end else begin
                want = pending_q.pop_front();
                if (seen.ch !== want.ch) report("channel_echo", seen.ch, want.ch);
                if (seen.lvl !== want.lvl) report("smoothed_level", seen.lvl, want.lvl);
                if (seen.score !== want.score) report("score_level", seen.score, want.score);
                if (seen.mn !== want.mn) report("stat_min", seen.mn, want.mn);
                if (seen.mx !== want.mx) report("stat_max", seen.mx, want.mx);
                if (seen.mean !== want.mean) report("stat_mean", seen.mean, want.mean);
                if (seen.cnt !== want.cnt) report("sample_count", seen.cnt, want.cnt);
            end
        end
        in_flight <= in_flight + int'(in_acc) - int'(out_acc);
        idle_run <= (in_acc || out_acc) ? 0 : idle_run + 1;
    end

    // result sink: random stall bursts, plus one long hold on request
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (SINK_HOLD) @(posedge aclk);
                hold_req <= 1'b0;
                m_ready <= 1'b1;
                @(posedge aclk);
            end else if (sink_idle && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        @(posedge aclk);
        while (idle_run < STALL_LIMIT) @(posedge aclk);
        $display("simulation failed");
        $finish;
    end

    task automatic apb_access(input logic wr, input logic [0:0] idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_alpha(input logic [0:0] idx, input logic [15:0] val);
        logic [31:0] back;
        apb_access(1'b1, idx, {16'd0, val}, back);
        if (idx == REG_RISE) rise_sh = val;
        else fall_sh = val;
        apb_access(1'b0, idx, 32'd0, back);
        if (back !== {16'd0, val}) report("alpha readback", back, val);
        alpha_writes++;
    endtask

    // valid stays up across back-to-back words; lowered only for a gap or a drain
    task automatic offer(input logic [3:0] ch, input logic signed [23:0] smp,
                         input logic signed [23:0] ovr, input logic typed,
                         input meter_word_t want);
        if (src_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_channel <= ch;
        s_sample <= smp;
        s_overall_score <= ovr;
        typed_ok <= typed;
        typed_word <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic pump(input int n);
        logic [3:0] ch;
        for (int i = 0; i < n; i++) begin
            ch = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(12, 15))
                                                : 4'($urandom_range(0, 11));
            offer(ch, pick_value(), pick_value(), 1'b0, '0);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (in_flight != 0) @(posedge aclk);
    endtask

    initial begin
        logic [31:0] back;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_channel <= '0;
        s_sample <= '0;
        s_overall_score <= '0;
        typed_ok <= 1'b0;
        typed_word <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        rise_sh = RISE_RESET;
        fall_sh = FALL_RESET;
        foreach (lvl_mem[i]) lvl_mem[i] = 0;
        foreach (cnt_mem[i]) begin
            min_mem[i] = 0;
            max_mem[i] = 0;
            mean_mem[i] = 0;
            cnt_mem[i] = 0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        apb_access(1'b0, REG_RISE, 32'd0, back);
        if (back !== {16'd0, RISE_RESET}) report("rise_alpha reset", back, RISE_RESET);
        apb_access(1'b0, REG_FALL, 32'd0, back);
        if (back !== {16'd0, FALL_RESET}) report("fall_alpha reset", back, FALL_RESET);

        foreach (PROBES[i]) begin
            offer(PROBES[i].ch, PROBES[i].smp, PROBES[i].ovr, PROBES[i].typed, PROBES[i].want);
        end
        drain_results();

        set_alpha(REG_RISE, 16'hFFFF);
        set_alpha(REG_FALL, 16'h0000);
        pump(150);
        // long sink hold with the source still pushing, so the block backs up
        hold_req <= 1'b1;
        src_idle = 1'b0;
        pump(12);
        drain_results();

        sink_idle <= 1'b0;
        set_alpha(REG_RISE, 16'h0000);
        set_alpha(REG_FALL, 16'hFFFF);
        pump(150);
        drain_results();

        src_idle = 1'b1;
        sink_idle <= 1'b1;
        set_alpha(REG_RISE, 16'($urandom));
        set_alpha(REG_FALL, 16'($urandom));
        pump(150);
        drain_results();

        set_alpha(REG_RISE, 16'h0000);
        set_alpha(REG_FALL, 16'h0000);
        pump(100);
        drain_results();

        set_alpha(REG_RISE, 16'($urandom));
        set_alpha(REG_FALL, 16'($urandom));
        pump(140);
        src_idle = 1'b0;
        sink_idle <= 1'b0;
        pump(50);
        drain_results();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_q.size() != 0) report("results never delivered", 0, pending_q.size());

        $display("covered %0d words over channels 0-15 under %0d alpha settings,",
                 words_in, alpha_writes);
        $display("%0d results compared, %0d mismatches", words_out, errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/msrs_pkg.sv
rtl/msrs_regs.sv
rtl/msrs_div.sv
rtl/msrs_dp.sv
rtl/msrs_ctrl.sv
rtl/meter_smoother_with_running_stats_core.sv
tb/tb_meter_smoother_with_running_stats_core.sv
